@@ src/wgm_pkg.sv @@
// Package with the shared constants and types of the wildcard glob matcher.
`timescale 1ns / 1ps

package wgm_pkg;

    localparam int MAX_PATTERN  = 16;
    localparam int STORED_BYTES = 16;
    localparam int EFF_MAX      = (MAX_PATTERN < STORED_BYTES) ? MAX_PATTERN : STORED_BYTES;
    localparam int LEN_W        = $clog2(EFF_MAX + 1);
    localparam int CFG_LEN_W    = 5;
    localparam int PAT_W        = 64;
    localparam int APB_DATA_W   = 64;
    localparam int APB_ADDR_W   = 5;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    localparam logic [1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [1:0] REG_PAT_LEN  = 2'd2;

    typedef struct packed {
        logic init_bit;
        logic old_bit;
        logic next_bit;
    } t_chain;

endpackage

@@ src/wildcard_glob_matcher_unit.sv @@
// Top level of the wildcard glob matcher: register port, cell row and output buffer.
`timescale 1ns / 1ps

// The matcher takes one text byte per clock cycle while o_stall is low and registers its
// match result in the output buffer when it accepts the request that carries the last byte
// or marks an empty string. Each byte passes through a row of 16 cells, one per pattern
// position, so the rate is one request per cycle unless the input is stalled; a two-entry
// output buffer keeps the input side moving while a result waits to be taken.

module wildcard_glob_matcher_unit
    import wgm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_is_last,
    input  logic                  i_is_empty,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_matched
);

    logic [PAT_W-1:0]     r_pat_low;
    logic [PAT_W-1:0]     r_pat_high;
    logic [CFG_LEN_W-1:0] r_pat_len;
    logic                 r_start;
    logic                 n_start;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_out_matched;
    logic                 n_out_matched;
    logic                 r_skid_valid;
    logic                 n_skid_valid;
    logic                 r_skid_matched;
    logic                 n_skid_matched;

    logic                   cfg_write;
    logic [1:0]             cfg_index;
    logic [2*PAT_W-1:0]     pattern;
    logic [LEN_W-1:0]       eff_len;
    logic                   in_accept;
    logic                   out_take;
    logic                   has_result;
    logic                   result_bit;
    t_chain                 chain [EFF_MAX+1];
    logic [EFF_MAX:0]       init_row;
    logic [EFF_MAX:0]       next_row;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = paddr[APB_ADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_PAT_LOW:  r_pat_low  <= pwdata;
                REG_PAT_HIGH: r_pat_high <= pwdata;
                REG_PAT_LEN:  r_pat_len  <= pwdata[CFG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_PAT_LOW:  prdata = r_pat_low;
            REG_PAT_HIGH: prdata = r_pat_high;
            REG_PAT_LEN:  prdata = {{(APB_DATA_W-CFG_LEN_W){1'b0}}, r_pat_len};
            default:      prdata = '0;
        endcase
    end

    assign pattern = {r_pat_high, r_pat_low};
    assign eff_len = (r_pat_len > CFG_LEN_W'(EFF_MAX)) ? LEN_W'(EFF_MAX)
                                                       : LEN_W'(r_pat_len);

    assign in_accept  = i_valid & ~o_stall;
    assign has_result = in_accept & (i_is_last | i_is_empty);

    assign chain[0].init_bit = 1'b1;
    assign chain[0].old_bit  = r_start;
    assign chain[0].next_bit = 1'b0;

    genvar j;
    generate
        for (j = 1; j <= EFF_MAX; j++) begin : g_cell
            wgm_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_pat_byte  (pattern[8*(j-1) +: 8]),
                .i_text_byte (i_text_byte),
                .i_enable    (LEN_W'(j) <= eff_len),
                .i_start     (r_start),
                .i_load      (in_accept & ~i_is_empty),
                .i_left      (chain[j-1]),
                .o_here      (chain[j])
            );
        end
        for (j = 0; j <= EFF_MAX; j++) begin : g_row
            assign init_row[j] = chain[j].init_bit;
            assign next_row[j] = chain[j].next_bit;
        end
    endgenerate

    assign result_bit = i_is_empty ? init_row[eff_len] : next_row[eff_len];

    always_comb begin
        n_start = r_start;
        if (in_accept) begin
            n_start = i_is_empty | i_is_last;
        end
    end

    assign out_take = r_out_valid & ~i_stall;

    always_comb begin
        n_out_valid    = r_out_valid;
        n_out_matched  = r_out_matched;
        n_skid_valid   = r_skid_valid;
        n_skid_matched = r_skid_matched;
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                n_out_valid   = 1'b1;
                n_out_matched = r_skid_matched;
                n_skid_valid  = 1'b0;
            end else begin
                n_out_valid   = has_result;
                n_out_matched = result_bit;
            end
        end else if (has_result) begin
            n_skid_valid   = 1'b1;
            n_skid_matched = result_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start      <= 1'b1;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_start      <= n_start;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_matched  <= n_out_matched;
        r_skid_matched <= n_skid_matched;
    end

    assign o_stall   = r_skid_valid;
    assign o_valid   = r_out_valid;
    assign o_matched = r_out_matched;

endmodule

@@ src/wgm_cell.sv @@
// One pattern position of the matcher row, holding its row bit.
`timescale 1ns / 1ps

module wgm_cell
    import wgm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_pat_byte,
    input  logic [7:0] i_text_byte,
    input  logic       i_enable,
    input  logic       i_start,
    input  logic       i_load,
    input  t_chain     i_left,
    output t_chain     o_here
);

    logic r_bit;
    logic n_bit;
    logic is_star;
    logic is_hit;
    logic init_bit;
    logic old_bit;
    logic next_bit;

    assign is_star  = (i_pat_byte == STAR_BYTE);
    assign is_hit   = (i_pat_byte == ANY_BYTE) || (i_pat_byte == i_text_byte);
    assign init_bit = i_enable & is_star & i_left.init_bit;
    assign old_bit  = i_start ? init_bit : r_bit;

    always_comb begin
        if (is_star) begin
            next_bit = i_enable & (i_left.next_bit | old_bit);
        end else begin
            next_bit = i_enable & is_hit & i_left.old_bit;
        end
    end

    assign n_bit = i_load ? next_bit : r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_here.init_bit = init_bit;
    assign o_here.old_bit  = old_bit;
    assign o_here.next_bit = next_bit;

endmodule

@@ src/wgm_checker.sv @@
// Port-level checks of the wildcard glob matcher and their binding to the top level.
`timescale 1ns / 1ps

module wgm_checker
    import wgm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic i_is_last,
    input logic i_is_empty,
    input logic o_valid,
    input logic i_stall,
    input logic o_matched
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_matched))
        else $error("Stalled result changed or was dropped.");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("Input stalled while no result is waiting.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("Input stall raised without a stalled result.");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_is_last || i_is_empty) && !o_valid |=> o_valid)
        else $error("Final request gave no result.");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_is_last && !i_is_empty && !o_valid |=> !o_valid)
        else $error("Result appeared for a request that ends no string.");

endmodule

bind wildcard_glob_matcher_unit wgm_checker u_wgm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_is_last  (i_is_last),
    .i_is_empty (i_is_empty),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_matched  (o_matched)
);

@@ bench/wgm_match_checker.sv @@
// Checker for the wildcard glob matcher: predicts every match result and compares it.
`timescale 1ns / 1ps

module wgm_match_checker
    import wgm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic                  i_req_valid,
    input  logic                  i_req_stall,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_is_last,
    input  logic                  i_is_empty,
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  logic                  i_matched,
    output int                    o_errors,
    output int                    o_pending
);

    logic [PAT_W-1:0]     pat_low;
    logic [PAT_W-1:0]     pat_high;
    logic [CFG_LEN_W-1:0] pat_len;
    logic [EFF_MAX:0]     prefix_hits;
    logic                 string_begins;
    logic                 expected_matches[$];

    function automatic int used_len();
        return (int'(pat_len) > EFF_MAX) ? EFF_MAX : int'(pat_len);
    endfunction

    function automatic logic [7:0] pat_byte_at(int k);
        logic [2*PAT_W-1:0] both;
        both = {pat_high, pat_low};
        return both[8*k +: 8];
    endfunction

    function automatic logic [EFF_MAX:0] start_row();
        logic [EFF_MAX:0] row;
        int               j;
        row = '0;
        row[0] = 1'b1;
        for (j = 1; j <= used_len(); j++) begin
            if (pat_byte_at(j - 1) == STAR_BYTE && row[j - 1]) begin
                row[j] = 1'b1;
            end
        end
        return row;
    endfunction

    function automatic logic [EFF_MAX:0] advance_row(logic [EFF_MAX:0] prev, logic [7:0] c);
        logic [EFF_MAX:0] row;
        logic [7:0]       p;
        int               j;
        row = '0;
        for (j = 1; j <= used_len(); j++) begin
            p = pat_byte_at(j - 1);
            if (p == STAR_BYTE) begin
                row[j] = row[j - 1] | prev[j];
            end else if (p == ANY_BYTE || p == c) begin
                row[j] = prev[j - 1];
            end
        end
        return row;
    endfunction

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            pat_low = '0;
            pat_high = '0;
            pat_len = '0;
            prefix_hits = start_row();
            string_begins = 1'b1;
            expected_matches.delete();
            o_errors = 0;
        end else begin
            if (i_req_valid && !i_req_stall) begin
                if (i_is_empty) begin
                    prefix_hits = start_row();
                    string_begins = 1'b1;
                    expected_matches.push_back(prefix_hits[used_len()]);
                end else begin
                    if (string_begins) begin
                        prefix_hits = start_row();
                    end
                    prefix_hits = advance_row(prefix_hits, i_text_byte);
                    string_begins = i_is_last;
                    if (i_is_last) begin
                        expected_matches.push_back(prefix_hits[used_len()]);
                    end
                end
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_matches.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("ERROR: result %0d seen with no request waiting", i_matched);
                    end
                end else begin
                    want = expected_matches.pop_front();
                    if (i_matched !== want) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("ERROR: matched expected %0d, got %0d", want, i_matched);
                        end
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_ADDR_W-1:3])
                    REG_PAT_LOW: pat_low = i_pwdata;
                    REG_PAT_HIGH: pat_high = i_pwdata;
                    REG_PAT_LEN: pat_len = i_pwdata[CFG_LEN_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_matches.size();
    end

endmodule

@@ bench/wildcard_glob_matcher_unit_test.sv @@
// Testbench top for the wildcard glob matcher: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module wildcard_glob_matcher_unit_test;
    import wgm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_text_byte = '0;
    logic                  i_is_last = 1'b0;
    logic                  i_is_empty = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_matched;

    int         fail_count;
    int         pending;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         hold_start = 0;
    int         hold_left = 0;
    int         items_sent = 0;
    int         cycle_count = 0;
    int         glob_len = 0;
    logic [7:0] glob_pat[STORED_BYTES];
    logic [7:0] text_q[$];

    wildcard_glob_matcher_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_text_byte (i_text_byte),
        .i_is_last   (i_is_last),
        .i_is_empty  (i_is_empty),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_matched   (o_matched)
    );

    wgm_match_checker match_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_req_valid (i_valid),
        .i_req_stall (o_stall),
        .i_text_byte (i_text_byte),
        .i_is_last   (i_is_last),
        .i_is_empty  (i_is_empty),
        .i_res_valid (o_valid),
        .i_res_stall (i_stall),
        .i_matched   (o_matched),
        .o_errors    (fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver counts its own long hold-off once one is requested.
    always @(negedge i_clk) begin
        if (hold_start > 0) begin
            hold_left = hold_start;
            hold_start = 0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input logic empty);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_text_byte <= b;
        i_is_last <= last;
        i_is_empty <= empty;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_text();
        int k;
        if (text_q.size() == 0) begin
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end else begin
            for (k = 0; k < text_q.size(); k++) begin
                send_byte(text_q[k], k == text_q.size() - 1, 1'b0);
            end
        end
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_pattern(input int len_value);
        logic [63:0] low;
        logic [63:0] high;
        int          k;
        for (k = 0; k < 8; k++) begin
            low[8*k +: 8] = glob_pat[k];
            high[8*k +: 8] = glob_pat[k + 8];
        end
        write_register(REG_PAT_LOW, low);
        write_register(REG_PAT_HIGH, high);
        write_register(REG_PAT_LEN, 64'(len_value));
        glob_len = ((len_value & 31) > EFF_MAX) ? EFF_MAX : (len_value & 31);
    endtask

    task automatic drain_results();
        while (pending != 0) @(negedge i_clk);
    endtask

    // A string without its last byte leaves no result behind, so wait for the block
    // to settle before the registers change.
    task automatic quiesce();
        i_valid <= 1'b0;
        drain_results();
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_text_byte();
        if ($urandom_range(99) < 75) begin
            return 8'h61 + 8'($urandom_range(1));
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        int r;
        r = $urandom_range(99);
        if (r < 22) begin
            return STAR_BYTE;
        end else if (r < 40) begin
            return ANY_BYTE;
        end else if (r < 90) begin
            return 8'h61 + 8'($urandom_range(1));
        end
        return 8'($urandom_range(255));
    endfunction

    // Expands the pattern into a text that should match, then sometimes spoils it.
    task automatic build_text();
        int k;
        text_q.delete();
        for (k = 0; k < glob_len; k++) begin
            if (glob_pat[k] == STAR_BYTE) begin
                repeat ($urandom_range(3)) text_q.push_back(pick_text_byte());
            end else if (glob_pat[k] == ANY_BYTE) begin
                text_q.push_back(pick_text_byte());
            end else begin
                text_q.push_back(glob_pat[k]);
            end
        end
        if ($urandom_range(99) < 30 && text_q.size() > 0) begin
            text_q[$urandom_range(text_q.size() - 1)] = pick_text_byte();
        end
        if ($urandom_range(99) < 10) begin
            text_q.push_back(pick_text_byte());
        end
        if ($urandom_range(99) < 8) begin
            text_q.delete();
        end
    endtask

    initial begin
        int   phase;
        int   goal;
        int   k;
        logic paused;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty pattern after reset: only the empty string matches.
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1);
        quiesce();

        glob_pat = '{STAR_BYTE, STAR_BYTE, 8'h00, ANY_BYTE, STAR_BYTE, 8'hFF, STAR_BYTE,
                     STAR_BYTE, STAR_BYTE, STAR_BYTE, STAR_BYTE, STAR_BYTE, STAR_BYTE,
                     STAR_BYTE, STAR_BYTE, STAR_BYTE};
        program_pattern(6);
        text_q.delete();
        send_text();
        text_q = '{8'h00, 8'h41, 8'hFF};
        send_text();
        text_q = '{8'h41, 8'h00, 8'h7F, 8'h12, 8'hFF};
        send_text();
        text_q = '{8'h00, 8'hFF};
        send_text();
        quiesce();

        // An oversized length saturates; then the length changes within a string.
        program_pattern(31);
        text_q = '{8'h00, 8'h55, 8'hFF};
        send_text();
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        quiesce();
        write_register(REG_PAT_LEN, 64'd2);
        send_byte(8'hFF, 1'b1, 1'b0);

        for (phase = 0; phase < 8; phase++) begin
            quiesce();
            for (k = 0; k < STORED_BYTES; k++) begin
                glob_pat[k] = pick_pattern_byte();
            end
            case (phase)
                0: program_pattern(16);
                1: program_pattern(31);
                2: program_pattern(1);
                3: program_pattern(0);
                4: program_pattern($urandom_range(31, 17));
                default: program_pattern($urandom_range(16));
            endcase
            case (phase % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 66;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 66;
                end
                default: begin
                    idle_pct = 12;
                    stall_pct = 12;
                end
            endcase
            if (phase == 4) begin
                hold_start = 80;
            end
            paused = 1'b0;
            goal = items_sent + 86;
            while (items_sent < goal) begin
                if (phase == 2 && !paused && items_sent > goal - 43) begin
                    i_valid <= 1'b0;
                    drain_results();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 5) begin
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
                end else begin
                    build_text();
                    send_text();
                end
            end
        end

        i_valid <= 1'b0;
        stall_pct = 0;
        drain_results();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
